// ===== rtl/ffrp_pkg.sv =====
`default_nettype none

package ffrp_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 32;
    localparam int MAX_SIDE_DEF    = 16;

    // Widths fixed by the item fields.
    localparam int SIDE_W = 5;
    localparam int OX_W   = 6;
    localparam int OY_W   = 5;

    typedef enum logic {
        OP_PLACE = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    typedef struct packed {
        t_op               operation;
        logic [SIDE_W-1:0] rect_height;
        logic [SIDE_W-1:0] rect_width;
    } t_in;

    typedef struct packed {
        logic            placed;
        logic [OX_W-1:0] origin_x;
        logic [OY_W-1:0] origin_y;
    } t_out;

    // Result of the column fit search over one candidate band of rows.
    typedef struct packed {
        logic            found;
        logic [OX_W-1:0] x;
    } t_fit;

endpackage

`default_nettype wire

// ===== rtl/ffrp_ram.sv =====
`default_nettype none

module ffrp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ffrp_fit.sv =====
`default_nettype none

module ffrp_fit #(
    parameter int GRID_WIDTH = 64,
    parameter int MAX_SIDE   = 16
) (
    input  wire logic                          i_clk,
    input  wire logic [GRID_WIDTH-1:0]         i_union,
    input  wire logic [ffrp_pkg::SIDE_W-1:0]   i_width,
    output ffrp_pkg::t_fit                     o_res
);

    import ffrp_pkg::*;

    logic [GRID_WIDTH+MAX_SIDE-1:0] ext;
    logic [MAX_SIDE-1:0]            wmask;
    logic [GRID_WIDTH-1:0]          fit;
    logic [GRID_WIDTH-1:0]          r_fit;

    // Columns past the right edge count as used, so a window that runs off
    // the grid never fits.
    assign ext = {{MAX_SIDE{1'b1}}, i_union};

    always_comb begin
        for (int k = 0; k < MAX_SIDE; k++) begin
            wmask[k] = (k < int'(i_width));
        end
        for (int x = 0; x < GRID_WIDTH; x++) begin
            fit[x] = ~|(ext[x +: MAX_SIDE] & wmask);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fit <= fit;
    end

    // Lowest fitting column wins.
    always_comb begin
        o_res.found = |r_fit;
        o_res.x     = '0;
        for (int x = GRID_WIDTH - 1; x >= 0; x--) begin
            if (r_fit[x]) begin
                o_res.x = OX_W'(x);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/first_fit_rect_placer.sv =====
`default_nettype none

// First-fit rectangle placer. The block holds a GRID_HEIGHT by GRID_WIDTH
// occupancy map, one RAM word per row, and answers every request beat with
// exactly one result beat. A place request scans top-left corners row by row
// and, within a row band, takes the lowest free column; it then marks the
// cells used and returns the origin. A clear request frees the whole map at
// once through per-row valid bits, so no sweep of the RAM is needed after
// reset or clear. Each candidate band of h rows is read through the single
// RAM read port into a union of used columns; the fit is then registered in
// the fit state and the pick state takes the lowest free column. Marking a
// found spot reads and rewrites the same h rows. The input is not ready
// while a request is in work.
module first_fit_rect_placer #(
    parameter int GRID_WIDTH  = ffrp_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ffrp_pkg::GRID_HEIGHT_DEF,
    parameter int MAX_SIDE    = ffrp_pkg::MAX_SIDE_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ffrp_pkg::t_in i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output ffrp_pkg::t_out     o_data
);

    import ffrp_pkg::*;

    localparam int YW = $clog2(GRID_HEIGHT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIT,
        S_PICK,
        S_MARK,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [YW-1:0]           r_y, n_y;
    logic [SIDE_W-1:0]       r_j, n_j;
    logic [SIDE_W-1:0]       r_h, n_h;
    logic [SIDE_W-1:0]       r_w, n_w;
    logic [OX_W-1:0]         r_x, n_x;
    logic [GRID_WIDTH-1:0]   r_union, n_union;
    logic                    r_pend, n_pend;
    logic                    r_rd_vld, n_rd_vld;
    logic [YW-1:0]           r_rd_addr, n_rd_addr;
    logic [GRID_HEIGHT-1:0]  r_row_valid, n_row_valid;
    logic                    r_placed, n_placed;
    logic                    r_out_valid, n_out_valid;
    t_out                    r_out, n_out;

    logic                    rd_en;
    logic [YW-1:0]           rd_addr;
    logic [GRID_WIDTH-1:0]   ram_q;
    logic [GRID_WIDTH-1:0]   row_q;
    logic                    wr_en;
    logic [GRID_WIDTH-1:0]   wmask_row;
    logic [GRID_WIDTH-1:0]   mark_mask;
    logic                    reject;
    t_fit                    fit_res;

    ffrp_ram #(
        .WIDTH (GRID_WIDTH),
        .DEPTH (GRID_HEIGHT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_rd_addr),
        .i_wr_data (row_q | mark_mask),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    ffrp_fit #(
        .GRID_WIDTH (GRID_WIDTH),
        .MAX_SIDE   (MAX_SIDE)
    ) u_fit (
        .i_clk   (i_clk),
        .i_union (r_union),
        .i_width (r_w),
        .o_res   (fit_res)
    );

    // A row that was never written since the last clear reads as free.
    assign row_q   = r_rd_vld ? ram_q : '0;
    assign rd_en   = ((r_state == S_SCAN) || (r_state == S_MARK)) && (r_j < r_h);
    assign rd_addr = r_y + YW'(r_j);
    assign wr_en   = (r_state == S_MARK) && r_pend;

    always_comb begin
        for (int k = 0; k < GRID_WIDTH; k++) begin
            wmask_row[k] = (k < int'(r_w));
        end
    end

    assign mark_mask = wmask_row << r_x;

    assign reject = (i_data.rect_height == '0) || (i_data.rect_width == '0) ||
                    (int'(i_data.rect_height) > MAX_SIDE) ||
                    (int'(i_data.rect_width) > MAX_SIDE) ||
                    (int'(i_data.rect_height) > GRID_HEIGHT) ||
                    (int'(i_data.rect_width) > GRID_WIDTH);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_y         = r_y;
        n_j         = r_j;
        n_h         = r_h;
        n_w         = r_w;
        n_x         = r_x;
        n_union     = r_union;
        n_pend      = rd_en;
        n_rd_vld    = r_row_valid[rd_addr];
        n_rd_addr   = rd_addr;
        n_row_valid = r_row_valid;
        n_placed    = r_placed;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_h = i_data.rect_height;
                    n_w = i_data.rect_width;
                    n_y = '0;
                    n_j = '0;
                    n_union = '0;
                    n_placed = 1'b0;
                    if (i_data.operation == OP_CLEAR) begin
                        n_row_valid = '0;
                        n_state = S_DONE;
                    end else if (reject) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_j = r_j + 1'b1;
                end
                if (r_pend) begin
                    n_union = r_union | row_q;
                end
                if (!rd_en && !r_pend) begin
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                n_j = '0;
                if (fit_res.found) begin
                    n_x = fit_res.x;
                    n_state = S_MARK;
                end else if (int'(r_y) + 1 + int'(r_h) <= GRID_HEIGHT) begin
                    n_y = r_y + 1'b1;
                    n_union = '0;
                    n_state = S_SCAN;
                end else begin
                    n_placed = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                if (rd_en) begin
                    n_j = r_j + 1'b1;
                end
                if (r_pend) begin
                    n_row_valid[r_rd_addr] = 1'b1;
                end
                if (!rd_en && !r_pend) begin
                    n_placed = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out.placed = r_placed;
                    n_out.origin_x = r_placed ? r_x : '0;
                    n_out.origin_y = r_placed ? OY_W'(r_y) : '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
            r_y         <= n_y;
            r_j         <= n_j;
            r_h         <= n_h;
            r_w         <= n_w;
            r_x         <= n_x;
            r_union     <= n_union;
            r_rd_vld    <= n_rd_vld;
            r_rd_addr   <= n_rd_addr;
            r_placed    <= n_placed;
            r_out       <= n_out;
        end
    end

    // A failed or clear beat never carries an origin.
    a_zero_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.placed) |-> (r_out.origin_x == '0 && r_out.origin_y == '0))
        else $error("unplaced result carries a nonzero origin");

    // The read counter never runs past the rectangle height.
    a_row_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_MARK) |-> (r_j <= r_h))
        else $error("row counter ran past the rectangle height");

    // Reads and row writes stay inside the grid.
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en || wr_en) |-> (int'(rd_addr) < GRID_HEIGHT && int'(r_rd_addr) < GRID_HEIGHT))
        else $error("row address outside the grid");

    // In the cycle after a request is taken the block is not ready.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready right after a request beat");

    // The marked columns stay inside the grid width.
    a_mark_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (int'(r_x) + int'(r_w) <= GRID_WIDTH))
        else $error("marked rectangle runs past the right edge");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ffrp_pkg::*;

    localparam int GRID_W = GRID_WIDTH_DEF;
    localparam int GRID_H = GRID_HEIGHT_DEF;
    localparam int SIDE_MAX = MAX_SIDE_DEF;

    // Keeps its own occupancy map and the queue of origins still owed by the block.
    class placement_scoreboard;
        logic [GRID_W-1:0] occupied [GRID_H];
        t_out pending_results[$];
        int errors;

        function new();
            foreach (occupied[r]) occupied[r] = '0;
            errors = 0;
        endfunction

        function void note_request(t_in req);
            t_out res;
            logic [GRID_W-1:0] band_used;
            logic [GRID_W-1:0] span;
            int h;
            int w;
            bit hit;
            h = int'(req.rect_height);
            w = int'(req.rect_width);
            res = '0;
            hit = 0;
            if (req.operation == OP_CLEAR) begin
                foreach (occupied[r]) occupied[r] = '0;
            end else if (h != 0 && w != 0 && h <= SIDE_MAX && w <= SIDE_MAX &&
                         h <= GRID_H && w <= GRID_W) begin
                for (int y = 0; y + h <= GRID_H && !hit; y++) begin
                    band_used = '0;
                    for (int j = 0; j < h; j++) band_used |= occupied[y + j];
                    for (int x = 0; x + w <= GRID_W && !hit; x++) begin
                        span = ((GRID_W'(1) << w) - 1) << x;
                        if ((band_used & span) == '0) begin
                            hit = 1;
                            for (int j = 0; j < h; j++) occupied[y + j] |= span;
                            res.placed = 1'b1;
                            res.origin_x = OX_W'(x);
                            res.origin_y = OY_W'(y);
                        end
                    end
                end
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                $error("result beat with no request outstanding: %p", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.placed !== want.placed) begin
                $error("placed: expected %0d, actual %0d", want.placed, got.placed);
                errors++;
            end
            if (got.origin_x !== want.origin_x) begin
                $error("origin_x: expected %0d, actual %0d", want.origin_x, got.origin_x);
                errors++;
            end
            if (got.origin_y !== want.origin_y) begin
                $error("origin_y: expected %0d, actual %0d", want.origin_y, got.origin_y);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    placement_scoreboard sb;
    bit quiet;

    first_fit_rect_placer dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #15ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_in rect_req(t_op op, int h, int w);
        t_in r;
        r.operation = op;
        r.rect_height = SIDE_W'(h);
        r.rect_width = SIDE_W'(w);
        return r;
    endfunction

    // Each further idle cycle comes with a chance of about a quarter, unless a quiet stretch is on.
    function automatic int idle_cycles();
        int n;
        n = 0;
        if (!quiet) begin
            while ($urandom_range(99) < 24) n++;
        end
        return n;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_request(t_in req);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= req;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
    end

    initial begin
        int pick;
        int h;
        int w;
        t_op op;
        sb = new();
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_request(rect_req(OP_CLEAR, 31, 31));
        send_request(rect_req(OP_PLACE, 1, 1));
        send_request(rect_req(OP_PLACE, 0, 5));
        send_request(rect_req(OP_PLACE, 5, 0));
        send_request(rect_req(OP_PLACE, 17, 1));
        send_request(rect_req(OP_PLACE, 1, 17));
        send_request(rect_req(OP_PLACE, 31, 31));
        send_request(rect_req(OP_CLEAR, 0, 0));
        // Eight maximal squares tile the map exactly, so the next beat finds no room.
        repeat (8) send_request(rect_req(OP_PLACE, SIDE_MAX, SIDE_MAX));
        send_request(rect_req(OP_PLACE, 1, 1));
        send_request(rect_req(OP_CLEAR, 16, 16));
        send_request(rect_req(OP_PLACE, SIDE_MAX, 1));
        send_request(rect_req(OP_PLACE, 1, SIDE_MAX));
        send_request(rect_req(OP_PLACE, SIDE_MAX, SIDE_MAX));
        send_request(rect_req(OP_PLACE, 3, 7));

        drain_results();
        @(negedge i_clk);

        for (int n = 0; n < 1150; n++) begin
            quiet = (n >= 500 && n < 700);
            if (n % 300 == 299) begin
                drain_results();
                @(negedge i_clk);
            end
            op = ($urandom_range(29) == 0) ? OP_CLEAR : OP_PLACE;
            pick = $urandom_range(99);
            if (pick < 70) begin
                h = $urandom_range(8, 1);
                w = $urandom_range(8, 1);
            end else if (pick < 90) begin
                h = $urandom_range(SIDE_MAX, 1);
                w = $urandom_range(SIDE_MAX, 1);
            end else begin
                h = $urandom_range(31);
                w = $urandom_range(31);
            end
            send_request(rect_req(op, h, w));
        end
        quiet = 1'b0;

        drain_results();
        repeat (400) @(negedge i_clk);
        if (sb.pending_results.size() != 0) begin
            $error("%0d results never arrived", sb.pending_results.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
